// ===== design/phlc_pkg.sv =====
package phlc_pkg;

  localparam int unsigned HISTORY_DEPTH = 64;
  localparam int unsigned IDX_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CNT_W         = $clog2(HISTORY_DEPTH + 1);

  localparam int unsigned POS_W  = 32;
  localparam int unsigned HEAD_W = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned DIST_W = 32;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [TIME_W-1:0] GAP_LIMIT_RESET = 32'd3357000000;

  localparam logic [REG_IDX_W-1:0] REG_MATCH_GAP_LIMIT = '0;

  localparam logic KIND_ODOM   = 1'b0;
  localparam logic KIND_VISION = 1'b1;

endpackage

// ===== design/phlc_if.sv =====
interface phlc_in_if;
  import phlc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic        [HEAD_W-1:0] heading;
  logic        [TIME_W-1:0] sample_time;
  logic signed [DIST_W-1:0] left_distance;
  logic signed [DIST_W-1:0] right_distance;

  modport source (
    output valid, kind, pos_x, pos_y, heading, sample_time, left_distance, right_distance,
    input  ready
  );

  modport sink (
    input  valid, kind, pos_x, pos_y, heading, sample_time, left_distance, right_distance,
    output ready
  );
endinterface

interface phlc_out_if;
  import phlc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  out_x;
  logic signed [POS_W-1:0]  out_y;
  logic        [HEAD_W-1:0] out_heading;
  logic signed [DIST_W-1:0] reset_left;
  logic signed [DIST_W-1:0] reset_right;
  logic                     reset_valid;

  modport source (
    output valid, out_x, out_y, out_heading, reset_left, reset_right, reset_valid,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_heading, reset_left, reset_right, reset_valid,
    output ready
  );
endinterface

// ===== design/pose_history_latency_corrector.sv =====
// Channel   Dir  Handshake      Word
// in_ch     in   valid/ready    kind, pos_x, pos_y, heading, sample_time, distances
// out_ch    out  valid/ready    out_x, out_y, out_heading, reset_left/right, reset_valid
// apb       in   psel/penable   match_gap_limit at byte address 0
//
// Odometry word, or vision word on an empty ring: the result goes through ST_PUSH to the
// output register. Vision word: search compares one stamp per cycle (k compared), then one
// x/y read-modify-write per cycle over the m newest entries, then through ST_PUSH to the
// output register; the next word is taken only once ST_PUSH has returned to ST_IDLE.
// in_ch.ready is high only when the sequencer is idle; a result waits in ST_PUSH while the
// output register is held. Reset clears ring pointers and distances, not the ring memories.
module pose_history_latency_corrector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  phlc_in_if.sink                             in_ch,
  phlc_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [phlc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [phlc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [phlc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import phlc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CORR,
    ST_PUSH
  } state_e;

  localparam logic [CNT_W:0]   DEPTH_S = (CNT_W+1)'(HISTORY_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HISTORY_DEPTH);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(HISTORY_DEPTH - 1);

  logic signed [POS_W-1:0]  ring_x       [HISTORY_DEPTH];
  logic signed [POS_W-1:0]  ring_y       [HISTORY_DEPTH];
  logic        [HEAD_W-1:0] ring_heading [HISTORY_DEPTH];
  logic        [TIME_W-1:0] ring_stamp   [HISTORY_DEPTH];

  state_e                   state_q;
  logic [IDX_W-1:0]         oldest_q;
  logic [CNT_W-1:0]         count_q;
  logic signed [DIST_W-1:0] last_left_q, last_right_q;
  logic [TIME_W-1:0]        gap_limit_q;

  logic signed [POS_W-1:0]  px_q, py_q;
  logic [TIME_W-1:0]        t_q;
  logic [TIME_W-1:0]        best_q;
  logic [CNT_W-1:0]         pick_q, rd_i_q, cmp_i_q, dat_i_q, newest_i_q;
  logic                     iss_q, cmp_vld_q, dat_vld_q;
  logic [IDX_W-1:0]         dat_slot_q;
  logic signed [POS_W:0]    ex_x_q, ex_y_q;

  logic signed [POS_W-1:0]  x_rd_q, y_rd_q;
  logic [HEAD_W-1:0]        h_rd_q;
  logic [TIME_W-1:0]        stamp_rd_q;

  logic signed [POS_W-1:0]  res_x_q, res_y_q;
  logic [HEAD_W-1:0]        res_h_q;
  logic                     res_valid_q;

  logic                     out_vld_q;
  logic signed [POS_W-1:0]  out_x_q, out_y_q;
  logic [HEAD_W-1:0]        out_h_q;
  logic signed [DIST_W-1:0] out_left_q, out_right_q;
  logic                     out_rv_q;

  logic                     in_acc, cfg_wr;
  logic [IDX_W-1:0]         rd_addr, odo_slot, wr_addr;
  logic                     wr_all_en, wr_xy_en;
  logic signed [POS_W-1:0]  wr_x, wr_y, new_x, new_y;
  logic [TIME_W-1:0]        gap;
  logic                     gap_lt, search_done;
  logic [CNT_W-1:0]         pick_nx;

  function automatic logic [IDX_W-1:0] slot_f(logic [IDX_W-1:0] base, logic [CNT_W-1:0] li);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(li);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] sat_add(logic signed [POS_W-1:0] a,
                                                     logic signed [POS_W:0] b);
    logic signed [POS_W+1:0] s;
    s = $signed({{2{a[POS_W-1]}}, a}) + $signed({b[POS_W], b});
    if (s[POS_W+1:POS_W-1] == 3'b000 || s[POS_W+1:POS_W-1] == 3'b111) begin
      return s[POS_W-1:0];
    end else if (s[POS_W+1]) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_q == ST_IDLE);
  assign cfg_wr       = psel && penable && pwrite && pready;
  assign pready       = 1'b1;
  assign prdata       = (paddr[APB_ADDR_W-1:2] == REG_MATCH_GAP_LIMIT) ? gap_limit_q : '0;

  assign out_ch.valid       = out_vld_q;
  assign out_ch.out_x       = out_x_q;
  assign out_ch.out_y       = out_y_q;
  assign out_ch.out_heading = out_h_q;
  assign out_ch.reset_left  = out_left_q;
  assign out_ch.reset_right = out_right_q;
  assign out_ch.reset_valid = out_rv_q;

  always_comb begin
    rd_addr   = slot_f(oldest_q, rd_i_q);
    odo_slot  = (count_q < DEPTH_C) ? slot_f(oldest_q, count_q) : oldest_q;
    gap       = (stamp_rd_q >= t_q) ? (stamp_rd_q - t_q) : (t_q - stamp_rd_q);
    gap_lt    = gap < best_q;
    pick_nx   = gap_lt ? cmp_i_q : pick_q;
    search_done = cmp_vld_q && (!gap_lt || cmp_i_q == '0);
    if (dat_i_q == pick_q) begin
      new_x = px_q;
      new_y = py_q;
    end else begin
      new_x = sat_add(x_rd_q, ex_x_q);
      new_y = sat_add(y_rd_q, ex_y_q);
    end
    wr_all_en = in_acc && (in_ch.kind == KIND_ODOM);
    wr_xy_en  = (state_q == ST_CORR) && dat_vld_q;
    wr_addr   = wr_all_en ? odo_slot : dat_slot_q;
    wr_x      = wr_all_en ? in_ch.pos_x : new_x;
    wr_y      = wr_all_en ? in_ch.pos_y : new_y;
  end

  always_ff @(posedge clk_i) begin
    if (wr_all_en || wr_xy_en) begin
      ring_x[wr_addr] <= wr_x;
      ring_y[wr_addr] <= wr_y;
    end
    if (wr_all_en) begin
      ring_heading[wr_addr] <= in_ch.heading;
      ring_stamp[wr_addr]   <= in_ch.sample_time;
    end
    x_rd_q     <= ring_x[rd_addr];
    y_rd_q     <= ring_y[rd_addr];
    h_rd_q     <= ring_heading[rd_addr];
    stamp_rd_q <= ring_stamp[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      oldest_q     <= '0;
      count_q      <= '0;
      last_left_q  <= '0;
      last_right_q <= '0;
      gap_limit_q  <= GAP_LIMIT_RESET;
      px_q         <= '0;
      py_q         <= '0;
      t_q          <= '0;
      best_q       <= '0;
      pick_q       <= '0;
      rd_i_q       <= '0;
      cmp_i_q      <= '0;
      dat_i_q      <= '0;
      newest_i_q   <= '0;
      iss_q        <= 1'b0;
      cmp_vld_q    <= 1'b0;
      dat_vld_q    <= 1'b0;
      dat_slot_q   <= '0;
      ex_x_q       <= '0;
      ex_y_q       <= '0;
      res_x_q      <= '0;
      res_y_q      <= '0;
      res_h_q      <= '0;
      res_valid_q  <= 1'b0;
      out_vld_q    <= 1'b0;
      out_x_q      <= '0;
      out_y_q      <= '0;
      out_h_q      <= '0;
      out_left_q   <= '0;
      out_right_q  <= '0;
      out_rv_q     <= 1'b0;
    end else begin
      cmp_vld_q <= 1'b0;
      dat_vld_q <= 1'b0;
      if (cfg_wr && paddr[APB_ADDR_W-1:2] == REG_MATCH_GAP_LIMIT) begin
        gap_limit_q <= pwdata[TIME_W-1:0];
      end
      if (out_vld_q && out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            px_q <= in_ch.pos_x;
            py_q <= in_ch.pos_y;
            t_q  <= in_ch.sample_time;
            if (in_ch.kind == KIND_ODOM) begin
              if (count_q < DEPTH_C) begin
                count_q <= count_q + 1'b1;
              end else begin
                oldest_q <= (oldest_q == LAST_SLOT) ? '0 : oldest_q + 1'b1;
              end
              last_left_q  <= in_ch.left_distance;
              last_right_q <= in_ch.right_distance;
              res_x_q      <= in_ch.pos_x;
              res_y_q      <= in_ch.pos_y;
              res_h_q      <= in_ch.heading;
              res_valid_q  <= 1'b0;
              state_q      <= ST_PUSH;
            end else if (count_q == '0) begin
              res_x_q     <= in_ch.pos_x;
              res_y_q     <= in_ch.pos_y;
              res_h_q     <= in_ch.heading;
              res_valid_q <= 1'b1;
              state_q     <= ST_PUSH;
            end else begin
              best_q     <= gap_limit_q;
              pick_q     <= '0;
              rd_i_q     <= count_q - 1'b1;
              newest_i_q <= count_q - 1'b1;
              iss_q      <= 1'b1;
              state_q    <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (iss_q) begin
            cmp_vld_q <= 1'b1;
            cmp_i_q   <= rd_i_q;
            rd_i_q    <= rd_i_q - 1'b1;
            iss_q     <= (rd_i_q != '0);
          end
          if (cmp_vld_q && gap_lt) begin
            best_q <= gap;
          end
          pick_q <= cmp_vld_q ? pick_nx : pick_q;
          if (search_done) begin
            cmp_vld_q <= 1'b0;
            rd_i_q    <= pick_nx;
            iss_q     <= 1'b1;
            state_q   <= ST_CORR;
          end
        end
        ST_CORR: begin
          if (iss_q) begin
            dat_vld_q  <= 1'b1;
            dat_i_q    <= rd_i_q;
            dat_slot_q <= rd_addr;
            rd_i_q     <= rd_i_q + 1'b1;
            iss_q      <= (rd_i_q != newest_i_q);
          end
          if (dat_vld_q) begin
            if (dat_i_q == pick_q) begin
              ex_x_q <= $signed({px_q[POS_W-1], px_q}) - $signed({x_rd_q[POS_W-1], x_rd_q});
              ex_y_q <= $signed({py_q[POS_W-1], py_q}) - $signed({y_rd_q[POS_W-1], y_rd_q});
            end
            if (dat_i_q == newest_i_q) begin
              res_x_q     <= new_x;
              res_y_q     <= new_y;
              res_h_q     <= h_rd_q;
              res_valid_q <= 1'b1;
              iss_q       <= 1'b0;
              state_q     <= ST_PUSH;
            end
          end
        end
        ST_PUSH: begin
          if (!out_vld_q || out_ch.ready) begin
            out_vld_q   <= 1'b1;
            out_x_q     <= res_x_q;
            out_y_q     <= res_y_q;
            out_h_q     <= res_h_q;
            out_left_q  <= last_left_q;
            out_right_q <= last_right_q;
            out_rv_q    <= res_valid_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
